[src/stbs_pkg.sv]
// shared types and constants of the sorted table search unit
`timescale 1ns / 1ps

package stbs_pkg;

   // fixed field widths of the item and result ports
   localparam int POS_BITS = 4;
   localparam int HIGH_BITS = 5;
   localparam int DATA_BITS = 32;
   localparam int LEN_BITS = 5;

   // search bounds run from -1 up to 16 while a search narrows
   localparam int CUR_BITS = 6;
   localparam int SUM_BITS = CUR_BITS + 1;

   // command queue between front and back
   localparam int QUEUE_SLOTS = 2;

   // csr port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_TABLE_LENGTH = 1'b0;
   localparam logic REG_DEFAULT_WORD = 1'b1;
   localparam logic [LEN_BITS-1:0] TABLE_LENGTH_RESET = 5'd16;

   // opcodes of an input item
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // what the back end has to do with an item
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_WRITE,
      KIND_READ,
      KIND_READ_DFLT,
      KIND_SEARCH,
      KIND_REFUSE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [POS_BITS-1:0]   pos;
      logic [DATA_BITS-1:0]  value;
      logic [POS_BITS-1:0]   lo;
      logic [POS_BITS-1:0]   hi;
   } cmd_type;

endpackage

[src/stbs_front.sv]
// front end: takes items and classifies them into back end commands
`timescale 1ns / 1ps

module stbs_front import stbs_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [POS_BITS-1:0]   req_position,
   input  logic [DATA_BITS-1:0]  req_data_value,
   input  logic [POS_BITS-1:0]   req_range_low,
   input  logic [HIGH_BITS-1:0]  req_range_high,
   input  logic [LEN_BITS-1:0]   table_length,
   input  logic                  clearing,
   input  logic                  push_ready,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic                pos_ok;
   logic                refuse;
   logic [POS_BITS-1:0] hi_val;

   // accept while the queue has room and the table is not being cleared
   assign req_ready = push_ready && !clearing;
   assign push = req_valid && req_ready;

   // range checks against the length in use
   assign hi_val = req_range_high[POS_BITS-1:0];
   assign pos_ok = (LEN_BITS'(req_position) < table_length)
                   && (int'(req_position) < DEPTH);
   assign refuse = (table_length == '0)
                   || req_range_high[HIGH_BITS-1]
                   || (req_range_low > hi_val)
                   || (LEN_BITS'(hi_val) >= table_length)
                   || (int'(hi_val) >= DEPTH);

   // classify the item
   always_comb begin
      push_cmd.pos = req_position;
      push_cmd.value = req_data_value;
      push_cmd.lo = req_range_low;
      push_cmd.hi = hi_val;
      unique case (req_opcode)
         OP_WRITE:  push_cmd.kind = pos_ok ? KIND_WRITE : KIND_NOP;
         OP_READ:   push_cmd.kind = pos_ok ? KIND_READ : KIND_READ_DFLT;
         OP_SEARCH: push_cmd.kind = refuse ? KIND_REFUSE : KIND_SEARCH;
         OP_UNUSED: push_cmd.kind = KIND_NOP;
      endcase
   end

endmodule

[src/stbs_queue.sv]
// short command queue between front and back end
`timescale 1ns / 1ps

module stbs_queue import stbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_BITS = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

   cmd_type             slot_ff [QUEUE_SLOTS];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign push_ready = count_ff != (PTR_BITS+1)'(QUEUE_SLOTS);
   assign pop_valid = count_ff != '0;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/stbs_back.sv]
// back end: table memory, read and search sequencer, result register
`timescale 1ns / 1ps

module stbs_back import stbs_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  cmd_type               q_cmd,
   output logic                  q_pop,
   input  logic [DATA_BITS-1:0]  default_word,
   output logic                  clearing,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_BITS-1:0]  rsp_read_word,
   output logic                  rsp_found,
   output logic                  rsp_range_error
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SEARCH
   } state_type;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 clr_cnt_ff, clr_cnt_in;
   logic signed [CUR_BITS-1:0]    lo_ff, lo_in;
   logic signed [CUR_BITS-1:0]    hi_ff, hi_in;
   logic [POS_BITS-1:0]           mid_ff, mid_in;
   logic signed [WORD_BITS-1:0]   tgt_ff, tgt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]          rsp_read_word_ff, rsp_read_word_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          rsp_range_error_ff, rsp_range_error_in;

   logic signed [WORD_BITS-1:0]   mem [DEPTH];
   logic signed [WORD_BITS-1:0]   rd_data_ff;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic signed [WORD_BITS-1:0]   wr_data;

   logic                          out_free;
   logic signed [WORD_BITS-1:0]   def_word;
   logic signed [WORD_BITS-1:0]   cmd_word;
   logic [POS_BITS:0]             start_sum;
   logic [POS_BITS-1:0]           start_mid;
   logic                          hit;
   logic                          above;
   logic signed [CUR_BITS-1:0]    mid_ext;
   logic signed [CUR_BITS-1:0]    nxt_lo;
   logic signed [CUR_BITS-1:0]    nxt_hi;
   logic signed [SUM_BITS-1:0]    nxt_sum;
   logic [POS_BITS-1:0]           nxt_mid;
   logic                          more;

   assign clearing = state_ff == ST_CLEAR;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_word = rsp_read_word_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_range_error = rsp_range_error_ff;

   // words as the table holds them
   assign def_word = WORD_BITS'($signed(default_word));
   assign cmd_word = WORD_BITS'($signed(q_cmd.value));

   // first probe of a new search
   assign start_sum = {1'b0, q_cmd.lo} + {1'b0, q_cmd.hi};
   assign start_mid = start_sum[POS_BITS:1];

   // one search step: compare the probed entry and narrow the range
   assign hit = rd_data_ff == tgt_ff;
   assign above = tgt_ff > rd_data_ff;
   assign mid_ext = $signed(CUR_BITS'(mid_ff));
   assign nxt_lo = above ? mid_ext + CUR_BITS'(1) : lo_ff;
   assign nxt_hi = above ? hi_ff : mid_ext - CUR_BITS'(1);
   assign more = !hit && (nxt_lo <= nxt_hi);
   assign nxt_sum = SUM_BITS'(nxt_lo) + SUM_BITS'(nxt_hi);
   assign nxt_mid = POS_BITS'(nxt_sum >>> 1);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      tgt_in = tgt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_read_word_in = rsp_read_word_ff;
      rsp_found_in = rsp_found_ff;
      rsp_range_error_in = rsp_range_error_ff;
      rd_en = 1'b0;
      rd_addr = AW'(q_cmd.pos);
      wr_en = 1'b0;
      wr_addr = AW'(q_cmd.pos);
      wr_data = cmd_word;
      q_pop = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  KIND_READ: begin
                     rd_en = 1'b1;
                     q_pop = 1'b1;
                     state_in = ST_READ;
                  end
                  KIND_SEARCH: begin
                     lo_in = $signed(CUR_BITS'(q_cmd.lo));
                     hi_in = $signed(CUR_BITS'(q_cmd.hi));
                     mid_in = start_mid;
                     tgt_in = cmd_word;
                     rd_en = 1'b1;
                     rd_addr = AW'(start_mid);
                     q_pop = 1'b1;
                     state_in = ST_SEARCH;
                  end
                  default: begin
                     // items that finish at once: write, default read, refusal, no-op
                     if (out_free) begin
                        q_pop = 1'b1;
                        wr_en = q_cmd.kind == KIND_WRITE;
                        rsp_valid_in = 1'b1;
                        rsp_read_word_in = (q_cmd.kind == KIND_READ_DFLT)
                                           ? DATA_BITS'(def_word) : '0;
                        rsp_found_in = 1'b0;
                        rsp_range_error_in = q_cmd.kind == KIND_REFUSE;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_read_word_in = DATA_BITS'(rd_data_ff);
               rsp_found_in = 1'b0;
               rsp_range_error_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (more) begin
               lo_in = nxt_lo;
               hi_in = nxt_hi;
               mid_in = nxt_mid;
               rd_en = 1'b1;
               rd_addr = AW'(nxt_mid);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_read_word_in = '0;
               rsp_found_in = hit;
               rsp_range_error_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      tgt_ff <= tgt_in;
      rsp_read_word_ff <= rsp_read_word_in;
      rsp_found_ff <= rsp_found_in;
      rsp_range_error_ff <= rsp_range_error_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[src/sorted_table_binary_search_unit.sv]
// top level of the sorted table search unit: csr registers and front/queue/back
`timescale 1ns / 1ps
//
// Usage: items enter on the req_ channel (valid/ready) with an opcode: write
// an entry, read an entry, or binary search a target over range_low..range_high
// of the ascending table. Every item gives exactly one result on the rsp_
// channel, in order. The csr_ port holds table_length (address 0) and
// default_word (address 4); write it only while no item is in flight.
// From acceptance to rsp_valid, a write, default read or refused search passes
// the queue and the result register; a read also passes the registered memory
// read, and a search makes p probes, with p <= log2(DEPTH) + 1, on the single
// memory read port, one probe per cycle.
// A two-entry queue lets the front accept while the back end works, and the
// result register lets the back end start the next item while a result waits.
// When rsp_ready is low the result holds and the back end stalls, then the
// queue fills and req_ready drops.
// Reset: registers return to length 16 and default 0, then the table is
// cleared to zero in a pass over all DEPTH entries, while req_ready stays low;
// csr writes are taken as usual.

module sorted_table_binary_search_unit import stbs_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [POS_BITS-1:0]       req_position,
   input  logic [DATA_BITS-1:0]      req_data_value,
   input  logic [POS_BITS-1:0]       req_range_low,
   input  logic [HIGH_BITS-1:0]      req_range_high,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DATA_BITS-1:0]      rsp_read_word,
   output logic                      rsp_found,
   output logic                      rsp_range_error,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   logic [LEN_BITS-1:0]  table_length_ff, table_length_in;
   logic [DATA_BITS-1:0] default_word_ff, default_word_in;
   logic                 csr_write;
   logic                 csr_sel;
   logic                 clearing;
   logic                 push;
   logic                 push_ready;
   cmd_type              push_cmd;
   logic                 q_valid;
   logic                 q_pop;
   cmd_type              q_cmd;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel = csr_paddr[2];

   always_comb begin
      table_length_in = table_length_ff;
      default_word_in = default_word_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_TABLE_LENGTH: table_length_in = csr_pwdata[LEN_BITS-1:0];
            REG_DEFAULT_WORD: default_word_in = csr_pwdata[DATA_BITS-1:0];
         endcase
      end
      unique case (csr_sel)
         REG_TABLE_LENGTH: csr_prdata = CSR_DATA_BITS'(table_length_ff);
         REG_DEFAULT_WORD: csr_prdata = CSR_DATA_BITS'(default_word_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= TABLE_LENGTH_RESET;
         default_word_ff <= '0;
      end else begin
         table_length_ff <= table_length_in;
         default_word_ff <= default_word_in;
      end
   end

   // item intake and classification
   stbs_front #(
      .DEPTH(DEPTH)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_data_value (req_data_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .table_length   (table_length_ff),
      .clearing       (clearing),
      .push_ready     (push_ready),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // command queue
   stbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd)
   );

   // table, search sequencer and result register
   stbs_back #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .default_word    (default_word_ff),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_word   (rsp_read_word),
      .rsp_found       (rsp_found),
      .rsp_range_error (rsp_range_error)
   );

endmodule
